>>> rtl/core/lfl_pkg.sv
// ----------------------------------------------------------------------------
// Linked free list allocator package
// Shared codes, payload structs and the step unit interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package lfl_pkg;

    // A link value of all ones marks the end of a chain.
    localparam logic [9:0] END_MARK          = 10'h3FF;
    localparam logic [8:0] RESERVED_AT_RESET = 9'd8;

    // Operation codes carried in the mode field.
    localparam logic [2:0] MODE_ALLOC      = 3'd0;
    localparam logic [2:0] MODE_FREE_ONE   = 3'd1;
    localparam logic [2:0] MODE_FREE_CHAIN = 3'd2;
    localparam logic [2:0] MODE_CLAIM      = 3'd3;
    localparam logic [2:0] MODE_RELEASE    = 3'd4;
    localparam logic [2:0] MODE_REBUILD    = 3'd5;

    // Status codes of a result.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [1:0] ST_BAD_ARG    = 2'd2;
    localparam logic [1:0] ST_PRIV_EMPTY = 2'd3;

    typedef struct packed {
        logic [2:0] mode;
        logic [9:0] alloc_count;
        logic [9:0] entry_ref;
        logic [9:0] caller_head;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] result_ref;
        logic [9:0] new_private_head;
        logic [9:0] free_total;
    } rsp_t;

    typedef struct packed {
        logic [9:0] a;
        logic [9:0] b;
        logic       sub;
    } step_req_t;

    typedef struct packed {
        logic [10:0] sum;
        logic        borrow;
        logic        zero;
    } step_rsp_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_ALLOC_RD,
        S_ALLOC_WT,
        S_FREE_RD,
        S_FREE_WT,
        S_FREE_END,
        S_CLAIM_WT,
        S_REBUILD,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/linked_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Linked free list allocator
// Free entries of a reference table form a singly linked list held in a
// link memory; a sequencer drives alloc, free, claim, release and rebuild.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req (req_valid/req_ready), one result per request leaves
// on rsp (rsp_valid/rsp_ready). reserved_count is written through cfg_we and
// cfg_wdata; the user must write it only while the block is idle, which the
// block itself does not enforce. One request is worked on at a time;
// req_ready is high only when idle. An alloc of N entries walks those N
// entries of the free list, a free chain walks its L entries and stops at the
// table size, and a rebuild relinks the entries from reserved_count up (none
// when it empties the list).
// Every walk step is a read of the single read port of the link memory,
// whose read data is registered.
// After reset the block sweeps every entry of the link memory to build the
// initial free list; req_ready stays low during that sweep.
// A finished result waits in the output register while the next request is
// taken; if the receiver still stalls when that one is done, the sequencer
// holds its result until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_free_list_allocator #(
    parameter int TABLE_ENTRIES = 512
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire lfl_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output lfl_pkg::rsp_t       rsp,
    input  wire logic           cfg_we,
    input  wire logic [8:0]     cfg_wdata
);

    localparam int         AW       = $clog2(TABLE_ENTRIES);
    localparam logic [9:0] TE_W     = 10'(TABLE_ENTRIES);
    localparam logic [9:0] LAST_IDX = 10'(TABLE_ENTRIES - 1);
    localparam logic [9:0] COUNT_AT_RESET =
        10'(TABLE_ENTRIES - int'(lfl_pkg::RESERVED_AT_RESET));

    lfl_pkg::state_t state_reg, state_next;

    logic [8:0]    reserved_reg;
    logic [9:0]    free_head_reg, free_head_next;
    logic [9:0]    free_count_reg, free_count_next;
    logic [9:0]    cur_reg, cur_next;
    logic [9:0]    n_reg, n_next;
    logic [9:0]    new_count_reg, new_count_next;
    logic          rd_ok_reg, rd_ok_next;
    lfl_pkg::req_t op_reg, op_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [9:0]    res_ref_reg, res_ref_next;
    logic [9:0]    res_newp_reg, res_newp_next;
    logic          rsp_valid_reg;
    lfl_pkg::rsp_t rsp_reg;
    logic          rsp_load;

    logic          mem_rd_en;
    logic [9:0]    mem_rd_idx;
    logic [9:0]    mem_rd_data;
    logic          mem_wr_en;
    logic [9:0]    mem_wr_idx;
    logic [9:0]    mem_wr_data;

    lfl_pkg::step_req_t step_req;
    lfl_pkg::step_rsp_t step_rsp;

    logic [9:0] link_val;
    logic       link_ok;
    logic       eref_ok;
    logic       phead_ok;
    logic       cur_ok;
    logic       alloc_last;
    logic [9:0] sat_count;

    lfl_link_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_link_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_idx[AW-1:0]),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_idx[AW-1:0]),
        .wr_data (mem_wr_data)
    );

    lfl_step_unit u_step (
        .req (step_req),
        .rsp (step_rsp)
    );

    // A read of an index outside the table returns the end mark.
    assign link_val   = rd_ok_reg ? mem_rd_data : lfl_pkg::END_MARK;
    assign link_ok    = (link_val < TE_W);
    assign eref_ok    = (op_reg.entry_ref < TE_W);
    assign phead_ok   = (op_reg.caller_head < TE_W);
    assign cur_ok     = (cur_reg < TE_W);
    assign alloc_last = (step_rsp.sum[9:0] == op_reg.alloc_count);
    assign sat_count  = (step_rsp.sum > {1'b0, TE_W}) ? TE_W : step_rsp.sum[9:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfl_pkg::S_INIT:
            begin
                if (cur_reg == LAST_IDX)
                begin
                    state_next = lfl_pkg::S_IDLE;
                end
            end
            lfl_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lfl_pkg::S_START;
                end
            end
            lfl_pkg::S_START:
            begin
                state_next = lfl_pkg::S_DONE;
                case (op_reg.mode)
                    lfl_pkg::MODE_ALLOC:
                    begin
                        if (op_reg.alloc_count != 10'd0 && !step_rsp.borrow)
                        begin
                            state_next = lfl_pkg::S_ALLOC_RD;
                        end
                    end
                    lfl_pkg::MODE_FREE_CHAIN:
                    begin
                        if (eref_ok)
                        begin
                            state_next = lfl_pkg::S_FREE_RD;
                        end
                    end
                    lfl_pkg::MODE_CLAIM:
                    begin
                        if (phead_ok)
                        begin
                            state_next = lfl_pkg::S_CLAIM_WT;
                        end
                    end
                    lfl_pkg::MODE_REBUILD:
                    begin
                        if (!step_rsp.borrow && !step_rsp.zero)
                        begin
                            state_next = lfl_pkg::S_REBUILD;
                        end
                    end
                    default:
                    begin
                        state_next = lfl_pkg::S_DONE;
                    end
                endcase
            end
            lfl_pkg::S_ALLOC_RD:
            begin
                state_next = lfl_pkg::S_ALLOC_WT;
            end
            lfl_pkg::S_ALLOC_WT:
            begin
                state_next = alloc_last ? lfl_pkg::S_DONE : lfl_pkg::S_ALLOC_RD;
            end
            lfl_pkg::S_FREE_RD:
            begin
                state_next = (n_reg == TE_W) ? lfl_pkg::S_FREE_END : lfl_pkg::S_FREE_WT;
            end
            lfl_pkg::S_FREE_WT:
            begin
                state_next = link_ok ? lfl_pkg::S_FREE_RD : lfl_pkg::S_FREE_END;
            end
            lfl_pkg::S_FREE_END:
            begin
                state_next = lfl_pkg::S_DONE;
            end
            lfl_pkg::S_CLAIM_WT:
            begin
                state_next = lfl_pkg::S_DONE;
            end
            lfl_pkg::S_REBUILD:
            begin
                if (cur_reg == LAST_IDX)
                begin
                    state_next = lfl_pkg::S_DONE;
                end
            end
            lfl_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = lfl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lfl_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        cur_next        = cur_reg;
        n_next          = n_reg;
        new_count_next  = new_count_reg;
        rd_ok_next      = rd_ok_reg;
        op_next         = op_reg;
        res_status_next = res_status_reg;
        res_ref_next    = res_ref_reg;
        res_newp_next   = res_newp_reg;
        rsp_load        = 1'b0;
        req_ready       = 1'b0;
        mem_rd_en       = 1'b0;
        mem_rd_idx      = cur_reg;
        mem_wr_en       = 1'b0;
        mem_wr_idx      = cur_reg;
        mem_wr_data     = lfl_pkg::END_MARK;
        step_req.a      = cur_reg;
        step_req.b      = 10'd1;
        step_req.sub    = 1'b0;

        case (state_reg)
            lfl_pkg::S_INIT:
            begin
                // Entries below the reset reservation start out linked to zero.
                mem_wr_en = 1'b1;
                if (cur_reg < 10'(lfl_pkg::RESERVED_AT_RESET))
                begin
                    mem_wr_data = 10'd0;
                end
                else if (cur_reg != LAST_IDX)
                begin
                    mem_wr_data = step_rsp.sum[9:0];
                end
                cur_next = step_rsp.sum[9:0];
            end
            lfl_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next         = req;
                    res_status_next = lfl_pkg::ST_OK;
                    res_ref_next    = lfl_pkg::END_MARK;
                    res_newp_next   = req.caller_head;
                end
            end
            lfl_pkg::S_START:
            begin
                case (op_reg.mode)
                    lfl_pkg::MODE_ALLOC:
                    begin
                        step_req.a   = free_count_reg;
                        step_req.b   = op_reg.alloc_count;
                        step_req.sub = 1'b1;
                        if (op_reg.alloc_count == 10'd0)
                        begin
                            res_status_next = lfl_pkg::ST_BAD_ARG;
                        end
                        else if (step_rsp.borrow)
                        begin
                            res_status_next = lfl_pkg::ST_NO_SPACE;
                        end
                        else
                        begin
                            new_count_next = step_rsp.sum[9:0];
                            res_ref_next   = free_head_reg;
                            cur_next       = free_head_reg;
                            n_next         = 10'd0;
                        end
                    end
                    lfl_pkg::MODE_FREE_ONE:
                    begin
                        step_req.a = free_count_reg;
                        if (!eref_ok)
                        begin
                            res_status_next = lfl_pkg::ST_BAD_ARG;
                        end
                        else
                        begin
                            mem_wr_en       = 1'b1;
                            mem_wr_idx      = op_reg.entry_ref;
                            mem_wr_data     = free_head_reg;
                            free_head_next  = op_reg.entry_ref;
                            free_count_next = sat_count;
                        end
                    end
                    lfl_pkg::MODE_FREE_CHAIN:
                    begin
                        // An empty chain is accepted and changes nothing.
                        if (eref_ok)
                        begin
                            cur_next = op_reg.entry_ref;
                            n_next   = 10'd1;
                        end
                        else if (op_reg.entry_ref != lfl_pkg::END_MARK)
                        begin
                            res_status_next = lfl_pkg::ST_BAD_ARG;
                        end
                    end
                    lfl_pkg::MODE_CLAIM:
                    begin
                        if (op_reg.caller_head == lfl_pkg::END_MARK)
                        begin
                            res_status_next = lfl_pkg::ST_PRIV_EMPTY;
                        end
                        else if (!phead_ok)
                        begin
                            res_status_next = lfl_pkg::ST_BAD_ARG;
                        end
                        else
                        begin
                            mem_rd_en  = 1'b1;
                            mem_rd_idx = op_reg.caller_head;
                            rd_ok_next = 1'b1;
                        end
                    end
                    lfl_pkg::MODE_RELEASE:
                    begin
                        if (!eref_ok)
                        begin
                            res_status_next = lfl_pkg::ST_BAD_ARG;
                        end
                        else
                        begin
                            mem_wr_en     = 1'b1;
                            mem_wr_idx    = op_reg.entry_ref;
                            mem_wr_data   = op_reg.caller_head;
                            res_newp_next = op_reg.entry_ref;
                        end
                    end
                    lfl_pkg::MODE_REBUILD:
                    begin
                        step_req.a   = TE_W;
                        step_req.b   = {1'b0, reserved_reg};
                        step_req.sub = 1'b1;
                        if (step_rsp.borrow || step_rsp.zero)
                        begin
                            free_head_next  = lfl_pkg::END_MARK;
                            free_count_next = 10'd0;
                        end
                        else
                        begin
                            new_count_next = step_rsp.sum[9:0];
                            cur_next       = {1'b0, reserved_reg};
                        end
                    end
                    default:
                    begin
                        res_status_next = lfl_pkg::ST_BAD_ARG;
                    end
                endcase
            end
            lfl_pkg::S_ALLOC_RD:
            begin
                mem_rd_en  = cur_ok;
                rd_ok_next = cur_ok;
            end
            lfl_pkg::S_ALLOC_WT:
            begin
                step_req.a = n_reg;
                n_next     = step_rsp.sum[9:0];
                if (alloc_last)
                begin
                    // The tail of the allocated chain gets the end mark.
                    free_head_next  = link_val;
                    mem_wr_en       = cur_ok;
                    free_count_next = new_count_reg;
                end
                else
                begin
                    cur_next = link_val;
                end
            end
            lfl_pkg::S_FREE_RD:
            begin
                if (n_reg != TE_W)
                begin
                    mem_rd_en  = 1'b1;
                    rd_ok_next = 1'b1;
                end
            end
            lfl_pkg::S_FREE_WT:
            begin
                step_req.a = n_reg;
                if (link_ok)
                begin
                    cur_next = link_val;
                    n_next   = step_rsp.sum[9:0];
                end
            end
            lfl_pkg::S_FREE_END:
            begin
                step_req.a      = free_count_reg;
                step_req.b      = n_reg;
                mem_wr_en       = 1'b1;
                mem_wr_data     = free_head_reg;
                free_head_next  = op_reg.entry_ref;
                free_count_next = sat_count;
            end
            lfl_pkg::S_CLAIM_WT:
            begin
                res_ref_next  = op_reg.caller_head;
                res_newp_next = link_val;
            end
            lfl_pkg::S_REBUILD:
            begin
                mem_wr_en = 1'b1;
                cur_next  = step_rsp.sum[9:0];
                if (cur_reg == LAST_IDX)
                begin
                    free_head_next  = {1'b0, reserved_reg};
                    free_count_next = new_count_reg;
                end
                else
                begin
                    mem_wr_data = step_rsp.sum[9:0];
                end
            end
            lfl_pkg::S_DONE:
            begin
                rsp_load = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lfl_pkg::S_INIT;
            reserved_reg   <= lfl_pkg::RESERVED_AT_RESET;
            free_head_reg  <= {1'b0, lfl_pkg::RESERVED_AT_RESET};
            free_count_reg <= COUNT_AT_RESET;
            cur_reg        <= 10'd0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            cur_reg        <= cur_next;
            if (cfg_we)
            begin
                reserved_reg <= cfg_wdata;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        new_count_reg  <= new_count_next;
        rd_ok_reg      <= rd_ok_next;
        op_reg         <= op_next;
        res_status_reg <= res_status_next;
        res_ref_reg    <= res_ref_next;
        res_newp_reg   <= res_newp_next;
        if (rsp_load)
        begin
            rsp_reg.status           <= res_status_reg;
            rsp_reg.result_ref       <= res_ref_reg;
            rsp_reg.new_private_head <= res_newp_reg;
            rsp_reg.free_total       <= free_count_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The free count never climbs above the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= TE_W)
        else $error("free count above table size");

    // Link memory writes only ever target entries inside the table.
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (mem_wr_idx < TE_W))
        else $error("link write outside the table");

    // A request transfer always starts the decode step next.
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == lfl_pkg::S_START))
        else $error("request transfer not followed by decode");

    // A new result is loaded only when the output register is free or draining.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

>>> rtl/core/lfl_link_mem.sv
// ----------------------------------------------------------------------------
// Link memory
// One next pointer per table entry; one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfl_link_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [9:0]    rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [9:0]    wr_data
);

    logic [9:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lfl_step_unit.sv
// ----------------------------------------------------------------------------
// Step unit
// The one adder/subtractor shared by the sequence steps: pointer and
// counter increments, free count updates and the space checks of alloc and rebuild.
// ----------------------------------------------------------------------------
`default_nettype none

module lfl_step_unit (
    input  wire lfl_pkg::step_req_t req,
    output lfl_pkg::step_rsp_t      rsp
);

    logic [10:0] sum;

    always_comb
    begin
        if (req.sub)
        begin
            sum = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            sum = {1'b0, req.a} + {1'b0, req.b};
        end
    end

    assign rsp.sum    = sum;
    assign rsp.borrow = req.sub & sum[10];
    assign rsp.zero   = (sum[9:0] == 10'd0);

endmodule

`default_nettype wire
